// ===== src/ecos_pkg.sv =====
// Package: types, constants and breakpoint tables for the envelope CV output shaper.
package ecos_pkg;

    localparam int CHANNELS    = 6;
    localparam int HOLD_TICKS  = 2000;
    localparam int QUIET_TICKS = 2000;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROM_POINTS  = 96;
    localparam int ROM_W       = $clog2(ROM_POINTS);

    localparam logic [12:0] PITCH_OFFSET   = 13'd22;
    localparam logic [12:0] PITCH_KMAX     = 13'd5166;
    localparam logic [30:0] TRIG_THRESHOLD = 31'h0200_0000;
    localparam logic [12:0] TRIG_DUTY      = 13'd4090;
    localparam logic [12:0] DUTY_MAX       = 13'd4096;
    localparam logic [12:0] PITCH_FLOOR    = 13'd42;

    localparam logic [2:0] STEP_NONE   = 3'd0;
    localparam logic [2:0] STEP_PREP   = 3'd1;
    localparam logic [2:0] STEP_MULT   = 3'd2;
    localparam logic [2:0] STEP_SEARCH = 3'd3;

    typedef enum logic [1:0] {
        REG_TRACK_MODE  = 2'd0,
        REG_TAP_POINT   = 2'd1,
        REG_ATTACK_COEF = 2'd2,
        REG_DECAY_COEF  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_PITCH    = 2'd0,
        MODE_ENVELOPE = 2'd1,
        MODE_TRIGGER  = 2'd2,
        MODE_TRIG_ALT = 2'd3
    } t_mode;

    typedef struct packed {
        logic [15:0] gain_5;
        logic [15:0] gain_4;
        logic [15:0] gain_3;
        logic [15:0] gain_2;
        logic [15:0] gain_1;
        logic [15:0] gain_0;
        logic [30:0] level_5;
        logic [30:0] level_4;
        logic [30:0] level_3;
        logic [30:0] level_2;
        logic [30:0] level_1;
        logic [30:0] level_0;
    } t_in;

    typedef struct packed {
        logic [12:0] duty_5;
        logic [12:0] duty_4;
        logic [12:0] duty_3;
        logic [12:0] duty_2;
        logic [12:0] duty_1;
        logic [12:0] duty_0;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP1,
        ST_STEP2,
        ST_STEP3,
        ST_STEP4,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic          load;
        logic [2:0]    step;
        logic [CH_W-1:0] ch;
        logic          commit;
    } t_cmd;

    typedef struct packed {
        logic          search_done;
    } t_stat;

    function automatic logic [12:0] bp_pos(input logic [ROM_W-1:0] i);
        logic [12:0] t [0:ROM_POINTS-1];
        t = '{
            13'd0,13'd1,13'd2,13'd3,13'd5,13'd6,13'd8,13'd10,13'd12,13'd14,
            13'd16,13'd18,13'd21,13'd23,13'd26,13'd29,13'd32,13'd35,13'd38,13'd42,
            13'd46,13'd50,13'd54,13'd59,13'd64,13'd69,13'd74,13'd80,13'd86,13'd92,
            13'd99,13'd106,13'd114,13'd122,13'd131,13'd140,13'd149,13'd160,13'd171,13'd182,
            13'd194,13'd207,13'd220,13'd235,13'd250,13'd267,13'd284,13'd302,13'd321,13'd342,
            13'd363,13'd386,13'd411,13'd436,13'd463,13'd492,13'd523,13'd556,13'd590,13'd626,
            13'd665,13'd705,13'd749,13'd795,13'd843,13'd895,13'd949,13'd1007,13'd1069,13'd1133,
            13'd1202,13'd1275,13'd1352,13'd1433,13'd1520,13'd1612,13'd1709,13'd1812,13'd1921,
            13'd2037,13'd2159,13'd2289,13'd2426,13'd2572,13'd2726,13'd2889,13'd3063,13'd3246,
            13'd3440,13'd3646,13'd3865,13'd4096,13'd4340,13'd4600,13'd4875,13'd5166};
        return t[i];
    endfunction

    function automatic logic [11:0] bp_val(input logic [ROM_W-1:0] i);
        logic [11:0] t [0:ROM_POINTS-1];
        t = '{
            12'd42,12'd84,12'd127,12'd169,12'd212,12'd255,12'd297,12'd340,12'd382,12'd425,
            12'd467,12'd510,12'd553,12'd595,12'd638,12'd680,12'd723,12'd766,12'd808,12'd851,
            12'd893,12'd936,12'd978,12'd1021,12'd1064,12'd1106,12'd1149,12'd1191,12'd1234,
            12'd1277,12'd1319,12'd1362,12'd1404,12'd1447,12'd1489,12'd1532,12'd1575,12'd1617,
            12'd1660,12'd1702,12'd1745,12'd1788,12'd1830,12'd1873,12'd1915,12'd1958,12'd2000,
            12'd2043,12'd2086,12'd2128,12'd2171,12'd2213,12'd2256,12'd2299,12'd2341,12'd2384,
            12'd2426,12'd2469,12'd2511,12'd2554,12'd2597,12'd2639,12'd2682,12'd2724,12'd2767,
            12'd2810,12'd2852,12'd2895,12'd2937,12'd2980,12'd3022,12'd3065,12'd3108,12'd3150,
            12'd3193,12'd3235,12'd3278,12'd3321,12'd3363,12'd3406,12'd3448,12'd3491,12'd3533,
            12'd3576,12'd3619,12'd3661,12'd3704,12'd3746,12'd3789,12'd3832,12'd3874,12'd3917,
            12'd3959,12'd4002,12'd4044,12'd4087};
        return t[i];
    endfunction

endpackage

// ===== src/ecos_div.sv =====
// Restoring divider: 24-bit dividend by 13-bit divisor, one quotient bit per cycle.
module ecos_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [12:0] i_den,
    output logic        o_done,
    output logic [23:0] o_quo
);
    logic [23:0] r_quo, n_quo;
    logic [13:0] r_rem, n_rem;
    logic [12:0] r_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [13:0] sh;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        sh     = {r_rem[12:0], r_quo[23]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 5'd24;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_den}) begin
                n_rem = sh - {1'b0, r_den};
                n_quo = {r_quo[22:0], 1'b1};
            end else begin
                n_rem = sh;
                n_quo = {r_quo[22:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_quo  = n_quo;
endmodule

// ===== src/ecos_datapath.sv =====
// Datapath: per-channel state, envelope filter, trigger logic and pitch interpolation.
module ecos_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ecos_pkg::t_cmd      i_cmd,
    output ecos_pkg::t_stat     o_stat,
    input  ecos_pkg::t_in       i_req,
    input  logic [1:0]          i_mode,
    input  logic                i_tap,
    input  logic [15:0]         i_attack,
    input  logic [15:0]         i_decay,
    output ecos_pkg::t_out      o_res
);
    import ecos_pkg::*;

    logic [30:0] r_level [CHANNELS];
    logic [15:0] r_gain  [CHANNELS];
    logic [47:0] r_filt  [CHANNELS];
    logic [10:0] r_hold  [CHANNELS];
    logic [10:0] r_quiet [CHANNELS];
    logic [12:0] r_duty  [CHANNELS];

    logic [30:0] lv;
    logic [15:0] gn;
    logic [47:0] env;
    assign lv  = r_level[i_cmd.ch];
    assign gn  = r_gain[i_cmd.ch];
    assign env = r_filt[i_cmd.ch];

    // step scratch registers
    logic [63:0] r_pa, r_pb;
    logic [47:0] r_x;
    logic [16:0] r_cm;
    logic [12:0] r_k;
    logic [ROM_W-1:0] r_idx;
    logic        r_div_go, r_div_wait;
    logic [46:0] r_lg;

    logic [46:0] lg_prod;
    assign lg_prod = lv * gn;

    // pitch index
    logic [27:0] kraw;
    logic [12:0] kval;
    always_comb begin
        kraw = lv[30:3];
        if (kraw > 28'(PITCH_OFFSET)) kraw = kraw - 28'(PITCH_OFFSET);
        else kraw = '0;
        if (kraw > 28'(PITCH_KMAX)) kval = PITCH_KMAX;
        else kval = kraw[12:0];
    end

    logic [12:0] pt, pb;
    logic [11:0] vt, vb;
    assign pt = bp_pos(r_idx);
    assign pb = bp_pos(r_idx - ROM_W'(1));
    assign vt = bp_val(r_idx);
    assign vb = bp_val(r_idx - ROM_W'(1));

    logic [23:0] num;
    assign num = 24'(pt - r_k) * 24'(vb) + 24'(r_k - pb) * 24'(vt);

    // bracket found (or last segment reached) while searching in pitch mode
    logic search_go;
    assign search_go = (i_cmd.step == STEP_SEARCH) && (i_mode == MODE_PITCH) &&
                       (r_k != '0) && !r_div_wait &&
                       ((r_k <= pt) || (r_idx == ROM_W'(ROM_POINTS - 1)));

    logic        div_done;
    logic [23:0] quo;
    ecos_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  (num),
        .i_den  (pt - pb),
        .o_done (div_done),
        .o_quo  (quo)
    );

    assign o_stat.search_done = (i_mode == MODE_PITCH) ?
        ((r_k == '0) || (!r_div_go && !r_div_wait && r_k != '0 && r_idx == '0) || div_done)
        : 1'b1;

    logic [47:0] new_env;
    assign new_env = 48'((r_pa + r_pb) >> 16);

    logic [12:0] n_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_filt[c]  <= '0;
                r_hold[c]  <= '0;
                r_quiet[c] <= '0;
                r_duty[c]  <= '0;
            end
            r_div_go   <= 1'b0;
            r_div_wait <= 1'b0;
            r_idx      <= '0;
            r_k        <= '0;
        end else begin
            r_div_go <= search_go;
            if (i_cmd.load) begin
                r_level[0] <= i_req.level_0; r_gain[0] <= i_req.gain_0;
                r_level[1] <= i_req.level_1; r_gain[1] <= i_req.gain_1;
                r_level[2] <= i_req.level_2; r_gain[2] <= i_req.gain_2;
                r_level[3] <= i_req.level_3; r_gain[3] <= i_req.gain_3;
                r_level[4] <= i_req.level_4; r_gain[4] <= i_req.gain_4;
                r_level[5] <= i_req.level_5; r_gain[5] <= i_req.gain_5;
            end
            case (i_cmd.step)
                STEP_PREP: begin
                    r_x  <= {1'b0, lv, 16'd0};
                    r_k  <= kval;
                    r_idx <= ROM_W'(1);
                    r_lg <= lg_prod;
                    r_div_wait <= 1'b0;
                    if ({1'b0, lv, 16'd0} > env) r_cm <= {1'b0, i_attack};
                    else r_cm <= {1'b0, i_decay};
                end
                STEP_MULT: begin
                    r_pa <= 64'(env) * 64'(r_cm[15:0]);
                    r_pb <= 64'(r_x) * 64'(17'h10000 - r_cm);
                end
                STEP_SEARCH: begin
                    // pitch bracket search, one point a cycle
                    if (i_mode == MODE_PITCH && r_k != '0 && !r_div_wait) begin
                        if (search_go) begin
                            r_div_wait <= 1'b1;
                        end else begin
                            r_idx <= r_idx + ROM_W'(1);
                        end
                    end
                end
                default: ;
            endcase
            if (i_cmd.commit) begin
                case (i_mode)
                    MODE_PITCH: begin
                        r_duty[i_cmd.ch] <= (r_k == '0) ? PITCH_FLOOR : quo[12:0];
                    end
                    MODE_ENVELOPE: begin
                        r_filt[i_cmd.ch] <= new_env;
                        if (!i_tap)
                            r_duty[i_cmd.ch] <= (new_env[47:34] > 14'(DUTY_MAX)) ?
                                DUTY_MAX : new_env[46:34];
                        else
                            r_duty[i_cmd.ch] <= n_duty;
                    end
                    default: begin
                        if (r_hold[i_cmd.ch] != '0) begin
                            r_hold[i_cmd.ch] <= r_hold[i_cmd.ch] - 11'd1;
                        end else if ((i_tap ? r_lg[46:16] : lv) > TRIG_THRESHOLD) begin
                            r_quiet[i_cmd.ch] <= '0;
                            r_hold[i_cmd.ch]  <= 11'(HOLD_TICKS);
                            r_duty[i_cmd.ch]  <= TRIG_DUTY;
                        end else begin
                            if (r_quiet[i_cmd.ch] < 11'(QUIET_TICKS))
                                r_quiet[i_cmd.ch] <= r_quiet[i_cmd.ch] + 11'd1;
                            if (r_quiet[i_cmd.ch] >= 11'(QUIET_TICKS - 1))
                                r_duty[i_cmd.ch] <= '0;
                        end
                    end
                endcase
            end
        end
    end

    // after-fader tap uses the freshly filtered envelope
    logic [63:0] eg;
    assign eg = 64'(new_env) * 64'(gn);
    assign n_duty = (eg[63:48] > 16'(DUTY_MAX)) ? DUTY_MAX : eg[60:48];

    assign o_res.duty_0 = r_duty[0];
    assign o_res.duty_1 = r_duty[1];
    assign o_res.duty_2 = r_duty[2];
    assign o_res.duty_3 = r_duty[3];
    assign o_res.duty_4 = r_duty[4];
    assign o_res.duty_5 = r_duty[5];
endmodule

// ===== src/ecos_ctrl.sv =====
// Controller: sequences the channels through the datapath steps.
module ecos_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  ecos_pkg::t_stat   i_stat,
    output ecos_pkg::t_cmd    o_cmd
);
    import ecos_pkg::*;

    t_state r_state, n_state;
    logic [CH_W-1:0] r_ch, n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        o_cmd   = '0;
        o_cmd.ch = r_ch;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_ch = '0;
                    n_state = ST_STEP1;
                end
            end
            ST_STEP1: begin
                o_cmd.step = STEP_PREP;
                n_state = ST_STEP2;
            end
            ST_STEP2: begin
                o_cmd.step = STEP_MULT;
                n_state = ST_STEP3;
            end
            ST_STEP3: begin
                o_cmd.step = STEP_SEARCH;
                if (i_stat.search_done) n_state = ST_STEP4;
            end
            ST_STEP4: begin
                o_cmd.commit = 1'b1;
                if (r_ch == CH_W'(CHANNELS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_ch = r_ch + CH_W'(1);
                    n_state = ST_STEP1;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== src/envelope_cv_output_shaper_top.sv =====
// Each request walks every channel in turn through the prepare, multiply, search and commit
// steps; in pitch mode the search step also waits for the bracket search and the divide.
// Throughput: one request at a time; the next is taken only once the result has been
// accepted and the controller has returned to idle.
// Synchronous active-low reset clears configuration to defaults and the filter, hold,
// quiet and duty state of every channel (levels and gains are not reset). Top level: envelope CV output shaper.
module envelope_cv_output_shaper_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ecos_pkg::t_in      i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ecos_pkg::t_out     o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import ecos_pkg::*;

    logic [1:0]  r_mode;
    logic        r_tap;
    logic [15:0] r_attack, r_decay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ENVELOPE;
            r_tap    <= 1'b0;
            r_attack <= 16'd58982;
            r_decay  <= 16'd65208;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_TRACK_MODE:  r_mode   <= i_cfg_data[1:0];
                REG_TAP_POINT:   r_tap    <= i_cfg_data[0];
                REG_ATTACK_COEF: r_attack <= i_cfg_data;
                REG_DECAY_COEF:  r_decay  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_cmd  cmd;
    t_stat stat;

    ecos_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    ecos_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_data),
        .i_mode  (r_mode),
        .i_tap   (r_tap),
        .i_attack(r_attack),
        .i_decay (r_decay),
        .o_res   (o_data)
    );
endmodule

// ===== src/ecos_checker.sv =====
// Checker: port-level properties of the shaper, bound to the top level.
module ecos_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input ecos_pkg::t_out o_data
);
    import ecos_pkg::*;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.duty_0 <= DUTY_MAX && o_data.duty_5 <= DUTY_MAX)
        else $error("duty out of range");
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid) else $error("result too early");
endmodule

bind envelope_cv_output_shaper_top ecos_checker u_chk (.*);
